### rtl/core/lbc_pkg.sv
package lbc_pkg;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_PRESS   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_BYTE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SEND_NONE = 2'd0,
        SEND_OK   = 2'd1,
        SEND_ON   = 2'd2,
        SEND_OFF  = 2'd3
    } send_t;

    typedef enum logic [1:0] {
        REG_LONG_PRESS     = 2'd0,
        REG_BLINK_INTERVAL = 2'd1,
        REG_BLINK_TOGGLES  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_PRESSED = 3'b010,
        PH_BLINK   = 3'b100
    } phase_t;

    localparam logic [6:0]  DUTY_TOP            = 7'd100;
    localparam logic [15:0] LONG_PRESS_RESET    = 16'd500;
    localparam logic [15:0] BLINK_INTERVAL_RESET = 16'd500;
    localparam logic [7:0]  BLINK_TOGGLES_RESET = 8'd6;
    localparam logic [7:0]  CHAR_CR             = 8'h0D;
    localparam logic [7:0]  CHAR_LF             = 8'h0A;
    localparam logic [3:0]  CMD_ON_LEN          = 4'd9;
    localparam logic [3:0]  CMD_OFF_LEN         = 4'd10;

    // Line decoder events for one received byte
    typedef struct packed {
        logic on;
        logic off;
    } line_cmd_t;

    typedef struct packed {
        logic       led_lit;
        logic       pwm_on;
        logic [6:0] duty_percent;
        send_t      send_code;
        logic       spi_valid;
        logic       spi_byte;
        logic       blinking;
    } result_t;

    // Character of "AT+LED_ON" at position i
    function automatic logic [7:0] cmd_on_char(input logic [3:0] i);
        logic [7:0] ch;
        case (i)
            4'd0:    ch = "A";
            4'd1:    ch = "T";
            4'd2:    ch = "+";
            4'd3:    ch = "L";
            4'd4:    ch = "E";
            4'd5:    ch = "D";
            4'd6:    ch = "_";
            4'd7:    ch = "O";
            4'd8:    ch = "N";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Character of "AT+LED_OFF" at position i
    function automatic logic [7:0] cmd_off_char(input logic [3:0] i);
        logic [7:0] ch;
        case (i)
            4'd0:    ch = "A";
            4'd1:    ch = "T";
            4'd2:    ch = "+";
            4'd3:    ch = "L";
            4'd4:    ch = "E";
            4'd5:    ch = "D";
            4'd6:    ch = "_";
            4'd7:    ch = "O";
            4'd8:    ch = "F";
            4'd9:    ch = "F";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### rtl/core/lbc_line.sv
module lbc_line #(
    parameter int LINE_MAX = 31
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_en,
    input  logic [7:0]        rx_byte,
    output lbc_pkg::line_cmd_t line_cmd
);
    import lbc_pkg::*;

    localparam int LEN_W = $clog2(LINE_MAX + 1);

    logic [LEN_W-1:0] len_reg, len_next;
    logic             on_ok_reg, on_ok_next;
    logic             off_ok_reg, off_ok_next;
    logic [3:0]       pos;
    logic             first;

    // Track prefix match against both commands instead of keeping the text
    always_comb
    begin
        len_next    = len_reg;
        on_ok_next  = on_ok_reg;
        off_ok_next = off_ok_reg;
        line_cmd    = '0;
        pos         = 4'(len_reg);
        first       = (len_reg == '0);
        if (byte_en)
        begin
            if (rx_byte == CHAR_CR || rx_byte == CHAR_LF)
            begin
                if (!first)
                begin
                    line_cmd.on  = (len_reg == LEN_W'(CMD_ON_LEN)) && on_ok_reg;
                    line_cmd.off = (len_reg == LEN_W'(CMD_OFF_LEN)) && off_ok_reg;
                    len_next     = '0;
                end
            end
            else if (len_reg < LEN_W'(LINE_MAX))
            begin
                on_ok_next  = (first || on_ok_reg) && (len_reg < LEN_W'(CMD_ON_LEN))
                              && (rx_byte == cmd_on_char(pos));
                off_ok_next = (first || off_ok_reg) && (len_reg < LEN_W'(CMD_OFF_LEN))
                              && (rx_byte == cmd_off_char(pos));
                len_next    = len_reg + 1'b1;
            end
            else
            begin
                // overflow: drop the line and this character
                len_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            on_ok_reg  <= 1'b0;
            off_ok_reg <= 1'b0;
        end
        else
        begin
            len_reg    <= len_next;
            on_ok_reg  <= on_ok_next;
            off_ok_reg <= off_ok_next;
        end
    end

endmodule

### rtl/core/lbc_ctrl.sv
module lbc_ctrl #(
    parameter int SLOTS_PER_PERIOD = 100
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  lbc_pkg::op_t       op,
    input  lbc_pkg::line_cmd_t line_cmd,
    input  logic [15:0]        long_press_ms,
    input  logic [15:0]        blink_interval_ms,
    input  logic [7:0]         blink_toggles,
    output lbc_pkg::result_t   result
);
    import lbc_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS_PER_PERIOD);

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [31:0]       press_age_reg, press_age_next;
    logic [31:0]       blink_age_reg, blink_age_next;
    logic [6:0]        duty_reg, duty_next;
    logic              ramp_down_reg, ramp_down_next;
    logic              mode_reg, mode_next;
    logic              reported_reg, reported_next;
    phase_t            phase_reg, phase_next;
    logic              blink_reg, blink_next;
    logic [7:0]        toggle_reg, toggle_next;
    logic              next_off_reg, next_off_next;
    logic              seen_reg, seen_next;
    logic              led_reg, led_next;

    logic              tick;
    logic              period_end;
    logic [SLOT_W-1:0] phase_pos;
    send_t             send;
    logic              spi_v;
    logic              spi_b;

    always_comb
    begin
        slot_next      = slot_reg;
        press_age_next = press_age_reg;
        blink_age_next = blink_age_reg;
        duty_next      = duty_reg;
        ramp_down_next = ramp_down_reg;
        mode_next      = mode_reg;
        reported_next  = reported_reg;
        phase_next     = phase_reg;
        blink_next     = blink_reg;
        toggle_next    = toggle_reg;
        next_off_next  = next_off_reg;
        seen_next      = seen_reg;
        led_next       = led_reg;
        tick           = 1'b0;
        period_end     = 1'b0;
        phase_pos      = slot_reg;
        send           = SEND_NONE;
        spi_v          = 1'b0;
        spi_b          = 1'b0;

        case (op)
            OP_TICK:
            begin
                tick = 1'b1;
                if (slot_reg == SLOT_W'(SLOTS_PER_PERIOD - 1))
                begin
                    slot_next  = '0;
                    period_end = 1'b1;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
                press_age_next = press_age_reg + 32'(period_end);
                blink_age_next = blink_age_reg + 32'(period_end);
            end
            OP_PRESS:
            begin
                press_age_next = '0;
                phase_next     = PH_PRESSED;
            end
            OP_RELEASE:
            begin
                if (phase_reg == PH_PRESSED)
                begin
                    if (press_age_reg >= {16'd0, long_press_ms})
                    begin
                        blink_next     = 1'b1;
                        toggle_next    = '0;
                        blink_age_next = '0;
                        phase_next     = PH_BLINK;
                    end
                    else
                    begin
                        mode_next  = ~mode_reg;
                        phase_next = PH_IDLE;
                    end
                end
            end
            OP_BYTE:
            begin
                if (line_cmd.on)
                begin
                    mode_next = 1'b1;
                    seen_next = 1'b1;
                    send      = SEND_OK;
                end
                else if (line_cmd.off)
                begin
                    mode_next = 1'b0;
                    seen_next = 1'b1;
                    send      = SEND_OK;
                end
            end
            default: ;
        endcase

        // blink toggle, and end of sequence with the command request
        if (blink_next && phase_next == PH_BLINK && blink_age_next >= {16'd0, blink_interval_ms})
        begin
            led_next       = ~toggle_next[0];
            toggle_next    = toggle_next + 8'd1;
            blink_age_next = '0;
            if (toggle_next >= blink_toggles)
            begin
                send          = next_off_reg ? SEND_OFF : SEND_ON;
                next_off_next = ~next_off_reg;
                blink_next    = 1'b0;
                phase_next    = PH_IDLE;
            end
        end

        // a received command cancels any running sequence
        if (blink_next && seen_next)
        begin
            blink_next = 1'b0;
            phase_next = PH_IDLE;
            seen_next  = 1'b0;
        end

        if (mode_next != reported_reg)
        begin
            reported_next = mode_next;
            spi_v         = 1'b1;
            spi_b         = mode_next;
        end

        if (!blink_next)
        begin
            if (mode_next)
            begin
                if (tick)
                begin
                    led_next = (8'(phase_pos) < {1'b0, duty_reg});
                    if (period_end)
                    begin
                        if (!ramp_down_reg)
                        begin
                            duty_next = duty_reg + 7'd1;
                            if (duty_next >= DUTY_TOP)
                            begin
                                duty_next      = DUTY_TOP;
                                ramp_down_next = 1'b1;
                            end
                        end
                        else
                        begin
                            if (duty_reg != '0)
                            begin
                                duty_next = duty_reg - 7'd1;
                            end
                            if (duty_next == '0)
                            begin
                                ramp_down_next = 1'b0;
                            end
                        end
                    end
                end
            end
            else
            begin
                led_next = 1'b0;
            end
        end

        result.led_lit      = led_next;
        result.pwm_on       = mode_next;
        result.duty_percent = duty_next;
        result.send_code    = send;
        result.spi_valid    = spi_v;
        result.spi_byte     = spi_b;
        result.blinking     = blink_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            press_age_reg <= '0;
            blink_age_reg <= '0;
            duty_reg      <= '0;
            ramp_down_reg <= 1'b0;
            mode_reg      <= 1'b0;
            reported_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            blink_reg     <= 1'b0;
            toggle_reg    <= '0;
            next_off_reg  <= 1'b0;
            seen_reg      <= 1'b0;
            led_reg       <= 1'b0;
        end
        else if (accept)
        begin
            slot_reg      <= slot_next;
            press_age_reg <= press_age_next;
            blink_age_reg <= blink_age_next;
            duty_reg      <= duty_next;
            ramp_down_reg <= ramp_down_next;
            mode_reg      <= mode_next;
            reported_reg  <= reported_next;
            phase_reg     <= phase_next;
            blink_reg     <= blink_next;
            toggle_reg    <= toggle_next;
            next_off_reg  <= next_off_next;
            seen_reg      <= seen_next;
            led_reg       <= led_next;
        end
    end

endmodule

### rtl/core/led_button_command_controller.sv
// Each result is registered and appears on the output in the cycle after its item is transferred.
// Throughput: one item per cycle; the input stalls only while a result waits
// in the output register and out_ready is low.
// Reset (rst_n, asynchronous, active low) clears all timing, mode, blink and
// line state and loads the register defaults 500 ms, 500 ms and 6 toggles.
module led_button_command_controller #(
    parameter int SLOTS_PER_PERIOD = 100,
    parameter int LINE_MAX         = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        led_lit,
    output logic        pwm_on,
    output logic [6:0]  duty_percent,
    output logic [1:0]  send_code,
    output logic        spi_valid,
    output logic        spi_byte,
    output logic        blinking,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lbc_pkg::*;

    logic        accept;
    op_t         op;
    line_cmd_t   line_cmd;
    result_t     result;
    result_t     result_reg;
    logic        out_valid_reg;
    logic [15:0] long_press_reg;
    logic [15:0] blink_interval_reg;
    logic [7:0]  blink_toggles_reg;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign op        = op_t'(opcode);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg     <= LONG_PRESS_RESET;
            blink_interval_reg <= BLINK_INTERVAL_RESET;
            blink_toggles_reg  <= BLINK_TOGGLES_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LONG_PRESS:     long_press_reg     <= cfg_data;
                REG_BLINK_INTERVAL: blink_interval_reg <= cfg_data;
                REG_BLINK_TOGGLES:  blink_toggles_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    lbc_line #(
        .LINE_MAX(LINE_MAX)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (accept && op == OP_BYTE),
        .rx_byte (rx_byte),
        .line_cmd(line_cmd)
    );

    lbc_ctrl #(
        .SLOTS_PER_PERIOD(SLOTS_PER_PERIOD)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .op               (op),
        .line_cmd         (line_cmd),
        .long_press_ms    (long_press_reg),
        .blink_interval_ms(blink_interval_reg),
        .blink_toggles    (blink_toggles_reg),
        .result           (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result until the downstream transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign led_lit      = result_reg.led_lit;
    assign pwm_on       = result_reg.pwm_on;
    assign duty_percent = result_reg.duty_percent;
    assign send_code    = result_reg.send_code;
    assign spi_valid    = result_reg.spi_valid;
    assign spi_byte     = result_reg.spi_byte;
    assign blinking     = result_reg.blinking;

endmodule

### rtl/core/lbc_checker.sv
module lbc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] duty_percent,
    input logic       spi_valid,
    input logic       spi_byte
);
    import lbc_pkg::*;

    // every input transfer yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no result after input transfer");

    // a pending result stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before transfer");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty_percent <= DUTY_TOP))
        else $error("duty out of range");

    a_spi_byte_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !spi_valid) |-> !spi_byte)
        else $error("spi_byte set without spi_valid");

endmodule

bind led_button_command_controller lbc_checker u_lbc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .duty_percent(duty_percent),
    .spi_valid   (spi_valid),
    .spi_byte    (spi_byte)
);

### sim/led_button_command_controller_tb.sv
`timescale 1ns / 100ps

module led_button_command_controller_tb;
    import lbc_pkg::*;

    localparam int SLOTS      = 100;
    localparam int LINE_LIMIT = 31;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } ctrl_item_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode    = OP_TICK;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        led_lit;
    logic        pwm_on;
    logic [6:0]  duty_percent;
    logic [1:0]  send_code;
    logic        spi_valid;
    logic        spi_byte;
    logic        blinking;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_LONG_PRESS;
    logic [15:0] cfg_data  = 16'h0000;

    ctrl_item_t ctrl_inputs[$];
    result_t    status_due[$];
    logic       in_fire = 1'b0;
    int         pushed = 0;
    int         status_errors = 0;
    int         send_idle = 0;
    int         recv_idle = 0;

    string on_cmd  = "AT+LED_ON";
    string off_cmd = "AT+LED_OFF";

    // Register copies
    logic [15:0] cfg_long     = LONG_PRESS_RESET;
    logic [15:0] cfg_interval = BLINK_INTERVAL_RESET;
    logic [7:0]  cfg_toggles  = BLINK_TOGGLES_RESET;

    // Controller state as the block should hold it
    logic [6:0]  m_slot     = '0;
    logic [31:0] m_now      = '0;
    logic [31:0] m_press_at = '0;
    logic [31:0] m_blink_at = '0;
    logic [6:0]  m_duty     = '0;
    logic        m_down     = 1'b0;
    logic        m_mode     = 1'b0;
    logic        m_reported = 1'b0;
    phase_t      m_phase    = PH_IDLE;
    logic        m_blinking = 1'b0;
    logic [7:0]  m_toggles  = '0;
    logic        m_next_off = 1'b0;
    logic        m_cmd_seen = 1'b0;
    logic        m_led      = 1'b0;
    int          m_len      = 0;
    logic [7:0]  m_line [0:LINE_LIMIT-1];

    led_button_command_controller #(
        .SLOTS_PER_PERIOD(SLOTS),
        .LINE_MAX(LINE_LIMIT)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .led_lit(led_lit),
        .pwm_on(pwm_on),
        .duty_percent(duty_percent),
        .send_code(send_code),
        .spi_valid(spi_valid),
        .spi_byte(spi_byte),
        .blinking(blinking),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit line_matches(input string s);
        bit same;
        same = (m_len == s.len());
        for (int i = 0; same && i < s.len(); i++)
            if (m_line[i] != s[i])
                same = 1'b0;
        return same;
    endfunction

    task automatic advance_controller(input op_t op, input logic [7:0] ch, output result_t r);
        send_t      code;
        logic       spi_v;
        logic       spi_b;
        logic       tick;
        logic       wrapped;
        logic [6:0] pos;
        code    = SEND_NONE;
        spi_v   = 1'b0;
        spi_b   = 1'b0;
        tick    = 1'b0;
        wrapped = 1'b0;
        pos     = '0;
        case (op)
            OP_TICK:
            begin
                tick   = 1'b1;
                pos    = m_slot;
                m_slot = m_slot + 7'd1;
                if (m_slot >= SLOTS)
                begin
                    m_slot  = '0;
                    m_now   = m_now + 32'd1;
                    wrapped = 1'b1;
                end
            end
            OP_PRESS:
            begin
                m_press_at = m_now;
                m_phase    = PH_PRESSED;
            end
            OP_RELEASE:
            begin
                if (m_phase == PH_PRESSED)
                begin
                    if ((m_now - m_press_at) >= {16'd0, cfg_long})
                    begin
                        m_blinking = 1'b1;
                        m_toggles  = '0;
                        m_blink_at = m_now;
                        m_phase    = PH_BLINK;
                    end
                    else
                    begin
                        m_mode  = ~m_mode;
                        m_phase = PH_IDLE;
                    end
                end
            end
            default:
            begin
                if (ch == CHAR_CR || ch == CHAR_LF)
                begin
                    if (m_len > 0)
                    begin
                        if (line_matches(on_cmd))
                        begin
                            m_mode     = 1'b1;
                            m_cmd_seen = 1'b1;
                            code       = SEND_OK;
                        end
                        else if (line_matches(off_cmd))
                        begin
                            m_mode     = 1'b0;
                            m_cmd_seen = 1'b1;
                            code       = SEND_OK;
                        end
                        m_len = 0;
                    end
                end
                else if (m_len < LINE_LIMIT)
                begin
                    m_line[m_len] = ch;
                    m_len++;
                end
                else
                begin
                    // full line: empty it and drop this character
                    m_len = 0;
                end
            end
        endcase

        if (m_blinking && m_phase == PH_BLINK && (m_now - m_blink_at) >= {16'd0, cfg_interval})
        begin
            m_led      = ~m_toggles[0];
            m_toggles  = m_toggles + 8'd1;
            m_blink_at = m_now;
            if (m_toggles >= cfg_toggles)
            begin
                code       = m_next_off ? SEND_OFF : SEND_ON;
                m_next_off = ~m_next_off;
                m_blinking = 1'b0;
                m_phase    = PH_IDLE;
            end
        end

        if (m_blinking && m_cmd_seen)
        begin
            m_blinking = 1'b0;
            m_phase    = PH_IDLE;
            m_cmd_seen = 1'b0;
        end

        if (m_mode != m_reported)
        begin
            m_reported = m_mode;
            spi_v      = 1'b1;
            spi_b      = m_mode;
        end

        if (!m_blinking)
        begin
            if (m_mode)
            begin
                if (tick)
                begin
                    m_led = (pos < m_duty);
                    if (wrapped)
                    begin
                        if (!m_down)
                        begin
                            m_duty = m_duty + 7'd1;
                            if (m_duty >= DUTY_TOP)
                            begin
                                m_duty = DUTY_TOP;
                                m_down = 1'b1;
                            end
                        end
                        else
                        begin
                            if (m_duty > 0)
                                m_duty = m_duty - 7'd1;
                            if (m_duty == 0)
                                m_down = 1'b0;
                        end
                    end
                end
            end
            else
            begin
                m_led = 1'b0;
            end
        end

        r.led_lit      = m_led;
        r.pwm_on       = m_mode;
        r.duty_percent = m_duty;
        r.send_code    = code;
        r.spi_valid    = spi_v;
        r.spi_byte     = spi_b;
        r.blinking     = m_blinking;
    endtask

    // Input driver and receiver stalls
    always @(negedge clk)
    begin : drive_inputs
        ctrl_item_t nxt;
        if (!in_valid || in_fire)
        begin
            if (rst_n && ctrl_inputs.size() > 0 && $urandom_range(0, 99) >= send_idle)
            begin
                nxt = ctrl_inputs.pop_front();
                in_valid <= 1'b1;
                opcode   <= nxt.op;
                rx_byte  <= nxt.ch;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Check each result transfer, then predict the one for an input transfer
    always @(posedge clk)
    begin : watch_outputs
        result_t seen;
        result_t want;
        result_t fresh;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen.led_lit      = led_lit;
                seen.pwm_on       = pwm_on;
                seen.duty_percent = duty_percent;
                seen.send_code    = send_t'(send_code);
                seen.spi_valid    = spi_valid;
                seen.spi_byte     = spi_byte;
                seen.blinking     = blinking;
                if (status_due.size() == 0)
                begin
                    status_errors++;
                    if (status_errors <= 10)
                        $display("unexpected result transfer at %0t", $realtime);
                end
                else
                begin
                    want = status_due.pop_front();
                    if (seen.led_lit !== want.led_lit || seen.pwm_on !== want.pwm_on ||
                        seen.duty_percent !== want.duty_percent ||
                        seen.send_code !== want.send_code || seen.spi_valid !== want.spi_valid ||
                        seen.spi_byte !== want.spi_byte || seen.blinking !== want.blinking)
                    begin
                        status_errors++;
                        if (status_errors <= 10)
                        begin
                            $display("mismatch at %0t", $realtime);
                            $display("exp led=%0b pwm=%0b duty=%0d send=%0d spi=%0b/%0b blink=%0b",
                                     want.led_lit, want.pwm_on, want.duty_percent,
                                     want.send_code, want.spi_valid, want.spi_byte,
                                     want.blinking);
                            $display("got led=%0b pwm=%0b duty=%0d send=%0d spi=%0b/%0b blink=%0b",
                                     seen.led_lit, seen.pwm_on, seen.duty_percent,
                                     seen.send_code, seen.spi_valid, seen.spi_byte,
                                     seen.blinking);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                advance_controller(op_t'(opcode), rx_byte, fresh);
                status_due.push_back(fresh);
            end
        end
        in_fire <= rst_n && in_valid && in_ready;
    end

    task automatic push_item(input op_t op, input logic [7:0] ch);
        ctrl_item_t it;
        it.op = op;
        it.ch = ch;
        ctrl_inputs.push_back(it);
        pushed++;
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_item(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_text(input string s, input int keep, input int bad_pos,
                             input logic [7:0] bad_ch);
        for (int i = 0; i < keep; i++)
            push_item(OP_BYTE, (i == bad_pos) ? bad_ch : s[i]);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_LONG_PRESS:     cfg_long     = val;
            REG_BLINK_INTERVAL: cfg_interval = val;
            REG_BLINK_TOGGLES:  cfg_toggles  = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] lp, input logic [15:0] bi, input logic [15:0] bt);
        cfg_write(REG_LONG_PRESS, lp);
        cfg_write(REG_BLINK_INTERVAL, bi);
        cfg_write(REG_BLINK_TOGGLES, bt);
    endtask

    // Wait until every queued item has produced its result, then let the pipe settle
    task automatic drain_all();
        while (ctrl_inputs.size() != 0 || in_valid || status_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic gen_traffic(input int n);
        int    target;
        int    pick;
        int    dur;
        int    lp_ticks;
        int    tail;
        int    tog;
        int    cut;
        int    bad;
        int    variant;
        string txt;
        target   = pushed + n;
        lp_ticks = int'(cfg_long) * SLOTS;
        tog      = (cfg_toggles == 8'd0) ? 1 : int'(cfg_toggles);
        tail     = int'(cfg_interval) * SLOTS * (tog + 1) + 100;
        if (tail > 600)
            tail = 600;
        while (pushed < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                push_ticks($urandom_range(1, 150));
            end
            else if (pick < 50 || (pick < 65 && lp_ticks > 2000))
            begin
                push_item(OP_PRESS, 8'($urandom_range(0, 255)));
                dur = (lp_ticks > 0) ?
                      $urandom_range(0, (lp_ticks > 300) ? 300 : lp_ticks - 1) : 0;
                push_ticks(dur);
                push_item(OP_RELEASE, 8'($urandom_range(0, 255)));
            end
            else if (pick < 65)
            begin
                push_item(OP_PRESS, 8'($urandom_range(0, 255)));
                push_ticks(lp_ticks + $urandom_range(0, 60));
                push_item(OP_RELEASE, 8'($urandom_range(0, 255)));
                dur = $urandom_range(0, tail);
                push_ticks(dur / 2);
                // press in mid sequence to freeze it
                if ($urandom_range(0, 4) == 0)
                begin
                    push_item(OP_PRESS, 8'($urandom_range(0, 255)));
                    push_ticks($urandom_range(0, 150));
                    push_item(OP_RELEASE, 8'($urandom_range(0, 255)));
                end
                push_ticks(dur - dur / 2);
            end
            else if (pick < 82)
            begin
                txt     = ($urandom_range(0, 1) != 0) ? on_cmd : off_cmd;
                cut     = txt.len();
                bad     = -1;
                variant = $urandom_range(0, 9);
                if (variant == 6)
                    bad = $urandom_range(0, txt.len() - 1);
                if (variant == 7)
                    cut = $urandom_range(1, txt.len() - 1);
                if ($urandom_range(0, 1) != 0)
                    push_item(OP_BYTE, CHAR_CR);
                if (variant == 8)
                    push_item(OP_BYTE, 8'($urandom_range(32, 126)));
                push_text(txt, cut, bad, 8'($urandom_range(0, 255)));
                if (variant == 9)
                    push_item(OP_BYTE, 8'($urandom_range(32, 126)));
                push_item(OP_BYTE, ($urandom_range(0, 1) != 0) ? CHAR_CR : CHAR_LF);
            end
            else if (pick < 90)
            begin
                // long printable lines, often past the line limit
                repeat ($urandom_range(20, 40)) push_item(OP_BYTE, 8'($urandom_range(32, 126)));
                push_item(OP_BYTE, ($urandom_range(0, 1) != 0) ? CHAR_CR : CHAR_LF);
            end
            else
            begin
                push_item(op_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
                target++;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle = 24;
        recv_idle = 58;

        // zero long press: every press long; zero toggles: one toggle ends it
        set_timing(16'd0, 16'd1, 16'd0);
        cfg_write(REG_UNUSED, 16'hFFFF);
        push_item(OP_BYTE, CHAR_LF);
        push_text(on_cmd, on_cmd.len(), -1, 8'h00);
        push_item(OP_BYTE, CHAR_CR);
        push_ticks(3);
        push_item(OP_PRESS, 8'h00);
        push_item(OP_RELEASE, 8'hFF);
        push_item(OP_PRESS, 8'hFF);
        push_item(OP_RELEASE, 8'h00);
        push_ticks(SLOTS);
        push_item(OP_RELEASE, 8'h5A);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_BYTE, CHAR_CR);
        push_text(off_cmd, 9, -1, 8'h00);
        push_item(OP_BYTE, CHAR_CR);
        push_text(off_cmd, off_cmd.len(), -1, 8'h00);
        push_item(OP_BYTE, CHAR_LF);
        repeat (LINE_LIMIT) push_item(OP_BYTE, "x");
        push_item(OP_BYTE, "y");
        push_text(on_cmd, on_cmd.len(), -1, 8'h00);
        push_item(OP_BYTE, CHAR_CR);
        drain_all();

        cfg_write(REG_BLINK_TOGGLES, 16'd3);
        push_item(OP_PRESS, 8'h00);
        push_item(OP_RELEASE, 8'h00);
        push_item(OP_PRESS, 8'h00);
        push_item(OP_RELEASE, 8'h00);
        push_ticks(SLOTS);
        push_item(OP_PRESS, 8'h00);
        push_ticks(SLOTS);
        push_item(OP_RELEASE, 8'h00);
        push_ticks(SLOTS);
        push_text(off_cmd, off_cmd.len(), -1, 8'h00);
        push_item(OP_BYTE, CHAR_CR);
        drain_all();

        set_timing(16'd2, 16'd1, 16'd3);
        gen_traffic(300);
        drain_all();

        send_idle = 58;
        recv_idle = 24;
        set_timing(16'd1, 16'd2, 16'd1);
        gen_traffic(200);
        // hold the sender until the block has answered everything
        drain_all();
        gen_traffic(200);
        drain_all();

        set_timing(16'd1, 16'd65535, 16'h00FF);
        gen_traffic(200);
        drain_all();

        send_idle = 0;
        recv_idle = 0;
        set_timing(16'd65535, 16'd1, 16'hAB02);
        gen_traffic(250);
        drain_all();

        set_timing(16'd0, 16'd1, 16'd0);
        gen_traffic(250);
        drain_all();

        set_timing(16'd3, 16'd1, 16'd4);
        gen_traffic(250);
        drain_all();

        // breathing run with an occasional stray byte
        push_item(OP_BYTE, CHAR_LF);
        push_text(on_cmd, on_cmd.len(), -1, 8'h00);
        push_item(OP_BYTE, CHAR_CR);
        repeat (200)
        begin
            if ($urandom_range(0, 49) == 0)
                push_item(OP_BYTE, 8'($urandom_range(32, 126)));
            else
                push_ticks(1);
        end
        drain_all();
        repeat (4) @(posedge clk);

        if (status_errors == 0 && status_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
